// ===== hw/rtl/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

	// Field widths of descriptors and results
	localparam int ARR_W   = 16;
	localparam int BURST_W = 12;
	localparam int PRIO_W  = 8;
	localparam int TIME_W  = 17;
	localparam int JOBID_W = 4;

	// Index width that covers the largest batch the chain can be built for
	localparam int IDX_W = 6;

	// Descriptor write into one cell
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} pps_load_t;

	// Service of one tick for the picked cell
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] fin;
	} pps_serve_t;

	// Search state handed from cell to cell
	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [IDX_W-1:0]  idx;
		logic              pending;
		logic [ARR_W-1:0]  next_arr;
	} pps_carry_t;

endpackage

// ===== hw/rtl/pps_if.sv =====
// Valid/ready channels for job descriptors and job results.
interface pps_job_if;
	logic        valid;
	logic        ready;
	logic [15:0] arrival_tick;
	logic [11:0] burst_len;
	logic [7:0]  prio_level;
	logic        last_job;

	modport source (output valid, arrival_tick, burst_len, prio_level, last_job, input ready);
	modport sink (input valid, arrival_tick, burst_len, prio_level, last_job, output ready);
endinterface

interface pps_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  job_index;
	logic [16:0] finish_tick;
	logic [16:0] wait_ticks;
	logic [16:0] turnaround_ticks;
	logic        last_result;

	modport source (output valid, job_index, finish_tick, wait_ticks, turnaround_ticks,
		last_result, input ready);
	modport sink (input valid, job_index, finish_tick, wait_ticks, turnaround_ticks,
		last_result, output ready);
endinterface

// ===== hw/rtl/pps_cell.sv =====
// One job slot of the scheduler chain: holds a descriptor and joins the search wave.
module pps_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pps_pkg::pps_load_t                wr,
	input  pps_pkg::pps_serve_t               serve,
	input  logic [CW-1:0]                     job_count,
	input  logic [pps_pkg::TIME_W-1:0]        sim_time,
	input  pps_pkg::pps_carry_t               carry_in,
	output pps_pkg::pps_carry_t               carry_q,
	output logic [pps_pkg::ARR_W-1:0]         arrival_q,
	output logic [pps_pkg::BURST_W-1:0]       burst_q,
	output logic [pps_pkg::TIME_W-1:0]        fin_q
);
	import pps_pkg::*;

	logic [BURST_W-1:0] rem_q;
	logic [PRIO_W-1:0]  prio_q;
	logic               active;
	logic               unfinished;
	logic               arrived;
	logic               elig;
	logic               later;
	logic               take;
	logic               take_next;
	pps_carry_t         carry_d;

	// Eligibility against the current tick
	assign active     = CW'(IDX) < job_count;
	assign unfinished = active && (rem_q != '0);
	assign arrived    = {1'b0, arrival_q} <= sim_time;
	assign elig       = unfinished && arrived;
	assign later      = unfinished && !arrived;

	// Lower index wins ties, so only a strictly smaller number replaces
	assign take      = elig && (!carry_in.found || (prio_q < carry_in.prio));
	assign take_next = later && (!carry_in.pending || (arrival_q < carry_in.next_arr));

	always_comb begin
		carry_d          = carry_in;
		carry_d.found    = carry_in.found | elig;
		carry_d.pending  = carry_in.pending | later;
		if (take) begin
			carry_d.prio = prio_q;
			carry_d.idx  = IDX_W'(IDX);
		end
		if (take_next) begin
			carry_d.next_arr = arrival_q;
		end
	end

	// Search wave register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	// Descriptor store; a zero burst finishes at its arrival
	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == IDX_W'(IDX))) begin
			arrival_q <= wr.arrival;
			burst_q   <= wr.burst;
			rem_q     <= wr.burst;
			prio_q    <= wr.prio;
			fin_q     <= {1'b0, wr.arrival};
		end else if (serve.en && (serve.idx == IDX_W'(IDX))) begin
			rem_q <= rem_q - BURST_W'(1);
			if (rem_q == BURST_W'(1)) begin
				fin_q <= serve.fin;
			end
		end
	end

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: control, cell chain and result stage.
//
// Descriptors are taken one per cycle while the block is loading; up to MAX_JOBS are kept
// and any beyond that are dropped. The beat with last_job set starts the run. Every
// simulated tick, busy or idle, takes one search: a search wave walks the chain
// of job cells, one cell per cycle, and the decision follows in the cycle after it leaves
// the last cell. An idle stretch costs one such search in all, as time jumps to the next
// arrival. One result beat per cycle, while res.ready allows it, then leaves in job order
// through an output register; the next batch may load as soon as the last result sits
// in that register.
module preemptive_priority_scheduler #(
	parameter int MAX_JOBS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	pps_job_if.sink  job,
	pps_res_if.source res
);
	import pps_pkg::*;

	localparam int CW  = $clog2(MAX_JOBS + 1);
	localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int WCW = $clog2(MAX_JOBS + 1);
	localparam logic [WCW-1:0] WAVE_END = WCW'(MAX_JOBS);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} pps_state_t;

	pps_state_t         state_q;
	logic [CW-1:0]      count_q;
	logic [TIME_W-1:0]  time_q;
	logic [WCW-1:0]     wave_q;
	logic [IW-1:0]      out_k_q;
	logic               out_valid_q;

	pps_load_t          wr;
	pps_serve_t         serve;
	pps_carry_t         chain [MAX_JOBS];
	pps_carry_t         last;
	logic [ARR_W-1:0]   view_arr   [MAX_JOBS];
	logic [BURST_W-1:0] view_burst [MAX_JOBS];
	logic [TIME_W-1:0]  view_fin   [MAX_JOBS];

	logic               decide;
	logic               out_free;
	logic               out_last;
	logic [TIME_W-1:0]  sel_fin;
	logic [TIME_W-1:0]  sel_turn;
	logic [TIME_W-1:0]  sel_wait;

	logic [JOBID_W-1:0] idx_q;
	logic [TIME_W-1:0]  fin_q;
	logic [TIME_W-1:0]  wait_q;
	logic [TIME_W-1:0]  turn_q;
	logic               last_q;

	// Handshake and broadcast controls
	assign job.ready = (state_q == ST_LOAD);
	assign last      = chain[MAX_JOBS-1];
	assign decide    = (state_q == ST_SCAN) && (wave_q == WAVE_END);
	assign out_free  = !out_valid_q || res.ready;
	assign out_last  = (CW'(out_k_q) + CW'(1)) == count_q;

	always_comb begin
		wr.en      = (state_q == ST_LOAD) && job.valid && (count_q < CW'(MAX_JOBS));
		wr.idx     = IDX_W'(count_q);
		wr.arrival = job.arrival_tick;
		wr.burst   = job.burst_len;
		wr.prio    = job.prio_level;
		serve.en   = decide && last.found;
		serve.idx  = last.idx;
		serve.fin  = time_q + TIME_W'(1);
	end

	// Chain of job cells, seeded empty at the low end
	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		pps_carry_t cin;
		if (i == 0) begin : g_seed
			assign cin = '0;
		end else begin : g_link
			assign cin = chain[i-1];
		end
		pps_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (wr),
			.serve     (serve),
			.job_count (count_q),
			.sim_time  (time_q),
			.carry_in  (cin),
			.carry_q   (chain[i]),
			.arrival_q (view_arr[i]),
			.burst_q   (view_burst[i]),
			.fin_q     (view_fin[i])
		);
	end

	// Control: load, tick by tick simulation, result drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			time_q      <= '0;
			wave_q      <= '0;
			out_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (job.valid) begin
						if (count_q < CW'(MAX_JOBS)) begin
							count_q <= count_q + CW'(1);
						end
						if (job.last_job) begin
							state_q <= ST_SCAN;
							time_q  <= '0;
							wave_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (wave_q == WAVE_END) begin
						wave_q <= '0;
						if (last.found) begin
							time_q <= time_q + TIME_W'(1);
						end else if (last.pending) begin
							time_q <= TIME_W'(last.next_arr);
						end else begin
							state_q <= ST_OUT;
							out_k_q <= '0;
						end
					end else begin
						wave_q <= wave_q + WCW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_k_q <= out_k_q + IW'(1);
						if (out_last) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result arithmetic for the selected job
	assign sel_fin  = view_fin[out_k_q];
	assign sel_turn = sel_fin - TIME_W'(view_arr[out_k_q]);
	assign sel_wait = sel_turn - TIME_W'(view_burst[out_k_q]);

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			idx_q  <= JOBID_W'(out_k_q);
			fin_q  <= sel_fin;
			wait_q <= sel_wait;
			turn_q <= sel_turn;
			last_q <= out_last;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.job_index        = idx_q;
	assign res.finish_tick      = fin_q;
	assign res.wait_ticks       = wait_q;
	assign res.turnaround_ticks = turn_q;
	assign res.last_result      = last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOBS))
		else $error("job count beyond store depth");

	a_serve_active: assert property (@(posedge clk) disable iff (!arst_n)
		serve.en |-> (CW'(serve.idx) < count_q))
		else $error("tick served to a slot outside the batch");

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (CW'(out_k_q) < count_q))
		else $error("result index past the batch");

	a_full_wave: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && ($past(state_q) == ST_SCAN)) |-> ($past(wave_q) == WAVE_END))
		else $error("run closed before the search wave left the chain");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the preemptive priority scheduler: directed table, then random batches.
`timescale 1ns / 1ps

module tb_top;
	import pps_pkg::*;

	localparam int MAX_JOBS    = 16;
	localparam int HOLD_CYCLES = 4000;
	localparam int PHASE_JOBS  = 85;

	// One job descriptor, with a hand-worked result where it is obvious
	typedef struct packed {
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic               last;
		logic               typed;
		logic [TIME_W-1:0]  finish;
		logic [TIME_W-1:0]  waiting;
		logic [TIME_W-1:0]  turnaround;
	} job_row_t;

	typedef struct packed {
		logic [JOBID_W-1:0] idx;
		logic [TIME_W-1:0]  finish;
		logic [TIME_W-1:0]  waiting;
		logic [TIME_W-1:0]  turnaround;
		logic               last;
	} job_result_t;

	logic clk;
	logic arst_n;

	pps_job_if job_bus ();
	pps_res_if res_bus ();

	preemptive_priority_scheduler #(
		.MAX_JOBS(MAX_JOBS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.job   (job_bus),
		.res   (res_bus)
	);

	// Directed table: zero burst, field extremes, preemption with a priority tie,
	// an idle stretch, and a full store whose closing descriptor is dropped
	job_row_t directed_rows [24] = '{
		'{16'd0,     12'd0,    8'd0,   1'b1, 1'b1, 17'd0,     17'd0, 17'd0},
		'{16'd65535, 12'd4095, 8'd255, 1'b1, 1'b1, 17'd69630, 17'd0, 17'd4095},
		'{16'd0,     12'd5,    8'd10,  1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd2,     12'd2,    8'd1,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd2,     12'd1,    8'd1,   1'b1, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd10,    12'd3,    8'd5,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd100,   12'd2,    8'd0,   1'b1, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd2,    8'd3,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd1,    8'd3,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd4,     12'd3,    8'd0,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd1,    8'd255, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd1,     12'd2,    8'd1,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd4,     12'd1,    8'd1,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd3,    8'd7,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd2,     12'd1,    8'd0,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd9,     12'd2,    8'd200, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd1,    8'd3,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd3,     12'd1,    8'd2,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd2,    8'd128, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd6,     12'd3,    8'd1,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd0,     12'd1,    8'd64,  1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd5,     12'd2,    8'd0,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd1,     12'd1,    8'd3,   1'b0, 1'b0, 17'd0, 17'd0, 17'd0},
		'{16'd1,     12'd1,    8'd0,   1'b1, 1'b0, 17'd0, 17'd0, 17'd0}
	};

	// Predictor state: the batch being loaded and the results still owed
	job_row_t    batch_jobs [MAX_JOBS];
	int          batch_len;
	job_result_t expected_results [$];

	int mismatches;
	int jobs_offered;
	int long_bursts_left;
	int send_idle_pct;
	int stall_pct;
	logic hold_results;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#36_000_000;
		$display("preemptive_priority_scheduler test failed");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Serve the stored batch tick by tick and queue one result per job, in load order
	function automatic void schedule_batch();
		logic [BURST_W-1:0] left [MAX_JOBS];
		logic [TIME_W-1:0]  fin [MAX_JOBS];
		logic [TIME_W-1:0]  now;
		logic [TIME_W-1:0]  next_arr;
		int                 done;
		int                 pick;
		bit                 found;
		job_result_t        r;

		now  = '0;
		done = 0;
		for (int k = 0; k < batch_len; k++) begin
			left[k] = batch_jobs[k].burst;
			fin[k]  = '0;
			// zero burst finishes on arrival
			if (left[k] == '0) begin
				fin[k] = TIME_W'(batch_jobs[k].arrival);
				done++;
			end
		end
		while (done < batch_len) begin
			found    = 1'b0;
			pick     = 0;
			next_arr = '1;
			for (int k = 0; k < batch_len; k++) begin
				if (left[k] != '0) begin
					if (TIME_W'(batch_jobs[k].arrival) <= now) begin
						// strict compare keeps the lowest index on a tie
						if (!found || batch_jobs[k].prio < batch_jobs[pick].prio) begin
							pick  = k;
							found = 1'b1;
						end
					end else if (TIME_W'(batch_jobs[k].arrival) < next_arr) begin
						next_arr = TIME_W'(batch_jobs[k].arrival);
					end
				end
			end
			if (!found) begin
				// nothing ready: jump to the next arrival
				now = next_arr;
			end else begin
				left[pick] = left[pick] - 1'b1;
				now        = now + 1'b1;
				if (left[pick] == '0) begin
					fin[pick] = now;
					done++;
				end
			end
		end
		for (int k = 0; k < batch_len; k++) begin
			r.idx        = JOBID_W'(k);
			r.finish     = fin[k];
			r.turnaround = fin[k] - TIME_W'(batch_jobs[k].arrival);
			r.waiting    = r.turnaround - TIME_W'(batch_jobs[k].burst);
			r.last       = (k == batch_len - 1);
			if (batch_jobs[k].typed) begin
				r.finish     = batch_jobs[k].finish;
				r.waiting    = batch_jobs[k].waiting;
				r.turnaround = batch_jobs[k].turnaround;
			end
			expected_results.push_back(r);
		end
	endfunction

	// Accepted descriptor: store it unless full, run the batch on the closing one
	function automatic void take_job(job_row_t row);
		if (batch_len < MAX_JOBS) begin
			batch_jobs[batch_len] = row;
			batch_len++;
		end
		if (row.last) begin
			schedule_batch();
			batch_len = 0;
		end
	endfunction

	// Offer one descriptor, after a random gap, and wait for its beat
	task automatic offer_job(job_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			job_bus.valid <= 1'b0;
			@(posedge clk);
		end
		job_bus.valid        <= 1'b1;
		job_bus.arrival_tick <= row.arrival;
		job_bus.burst_len    <= row.burst;
		job_bus.prio_level   <= row.prio;
		job_bus.last_job     <= row.last;
		do @(posedge clk); while (!job_bus.ready);
		take_job(row);
		jobs_offered++;
	endtask

	// Sender pauses until every owed result has come back
	task automatic drain_results();
		job_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// One well-formed batch with random content; quick ones stay short and cheap
	task automatic send_random_batch(bit quick);
		int       n;
		int       roll;
		bit       spread;
		bit       narrow_prio;
		job_row_t row;

		roll = $urandom_range(99);
		if (quick) n = $urandom_range(4, 1);
		else if (roll < 8) n = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
		else if (roll < 30) n = $urandom_range(MAX_JOBS, 9);
		else n = $urandom_range(8, 1);
		spread      = !quick && ($urandom_range(99) < 15);
		narrow_prio = $urandom_range(1);
		for (int k = 0; k < n; k++) begin
			row         = '0;
			row.arrival = spread ? ARR_W'($urandom_range(65535)) : ARR_W'($urandom_range(31));
			roll        = $urandom_range(99);
			if (roll < 10) begin
				row.burst = '0;
			end else if (!quick && roll < 15) begin
				row.burst = BURST_W'($urandom_range(255, 16));
			end else if (!quick && roll == 15 && long_bursts_left > 0) begin
				// long bursts are slow to simulate, so only a few
				row.burst = BURST_W'($urandom_range(4095));
				long_bursts_left--;
			end else begin
				row.burst = BURST_W'($urandom_range(15, 1));
			end
			row.prio = narrow_prio ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
			row.last = (k == n - 1);
			offer_job(row);
		end
	endtask

	task automatic run_phase(int idle, int stall);
		int start;

		send_idle_pct = idle;
		stall_pct     = stall;
		start         = jobs_offered;
		while (jobs_offered - start < PHASE_JOBS) send_random_batch(1'b0);
		drain_results();
	endtask

	task automatic check_result();
		job_result_t want;

		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result for job %0d with none outstanding",
				res_bus.job_index));
		end else begin
			want = expected_results.pop_front();
			if (res_bus.job_index !== want.idx)
				report_mismatch($sformatf("job_index %0d, want %0d", res_bus.job_index, want.idx));
			if (res_bus.finish_tick !== want.finish)
				report_mismatch($sformatf("job %0d finish_tick %0d, want %0d", want.idx,
					res_bus.finish_tick, want.finish));
			if (res_bus.wait_ticks !== want.waiting)
				report_mismatch($sformatf("job %0d wait_ticks %0d, want %0d", want.idx,
					res_bus.wait_ticks, want.waiting));
			if (res_bus.turnaround_ticks !== want.turnaround)
				report_mismatch($sformatf("job %0d turnaround_ticks %0d, want %0d", want.idx,
					res_bus.turnaround_ticks, want.turnaround));
			if (res_bus.last_result !== want.last)
				report_mismatch($sformatf("job %0d last_result %0b, want %0b", want.idx,
					res_bus.last_result, want.last));
		end
	endtask

	// Result side: check each beat, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) check_result();
			if (hold_results) res_bus.ready <= 1'b0;
			else res_bus.ready <= ($urandom_range(99) >= stall_pct);
		end else begin
			res_bus.ready <= 1'b0;
		end
	end

	// Stimulus
	initial begin
		arst_n               = 1'b0;
		job_bus.valid        = 1'b0;
		job_bus.arrival_tick = '0;
		job_bus.burst_len    = '0;
		job_bus.prio_level   = '0;
		job_bus.last_job     = 1'b0;
		hold_results         = 1'b0;
		batch_len            = 0;
		mismatches           = 0;
		jobs_offered         = 0;
		long_bursts_left     = 3;
		send_idle_pct        = 0;
		stall_pct            = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) offer_job(directed_rows[i]);
		drain_results();

		run_phase(0, 0);

		// long hold on results while further batches queue up at the input
		fork
			begin
				hold_results <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results <= 1'b0;
			end
		join_none
		repeat (3) send_random_batch(1'b1);
		drain_results();

		run_phase(77, 0);
		run_phase(0, 77);
		run_phase(29, 29);

		// catch any stray beat after the last one
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("preemptive_priority_scheduler test passed");
		end else begin
			$display("preemptive_priority_scheduler test failed");
		end
		$finish;
	end

endmodule
